@@ hdl/rmdc_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Recent-MAC dedup cache package
// Shared constants, command codes, control state and chain control word.
// ----------------------------------------------------------------------------
package rmdc_pkg;

	localparam int DEPTH_DEF   = 256;
	localparam int HASH_W      = 32;
	localparam int MAC_W       = 48;
	localparam int MAC_BYTES   = 6;
	localparam int BYTE_CNT_W  = 3;

	localparam logic [HASH_W-1:0] HASH_SEED = 32'd5381;

	localparam logic CMD_CHECK = 1'b0;
	localparam logic CMD_CLEAR = 1'b1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_HASH,
		ST_SEARCH,
		ST_INSERT,
		ST_DONE
	} ctrl_state_t;

	// advance: every cell takes its neighbour's word
	// load_new: cell 0 takes the fresh hash instead of the wrapped tail
	typedef struct packed {
		logic advance;
		logic load_new;
	} chain_ctl_t;

endpackage
`default_nettype wire

@@ hdl/recent_mac_dedup_cache_top.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Recent-MAC dedup cache
// Hashes a MAC address and checks it against the most recent DEPTH distinct
// hashes, inserting it on a miss with oldest-first replacement.
// ----------------------------------------------------------------------------
// One word is worked at a time. A check word passes through the hash fold, a
// full search lap of the chain, an insert on a miss (a hit skips it) and the
// output load; a clear word goes straight to the output load. The next word is
// taken in the cycle after the output load, and a result held up by a stalled
// output register holds the block in its done state. The search runs through
// the cell chain: the stored hashes rotate through the chain one cell per cycle
// past a single comparator, and a full lap is always made so the chain returns
// to its original order. A new word is accepted as soon as the block is idle,
// even while the previous result still waits in the output register. There is
// no clearing pass after reset.
// ----------------------------------------------------------------------------
module recent_mac_dedup_cache_top #(
	parameter int DEPTH = rmdc_pkg::DEPTH_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output      logic        s_tready,
	input  wire logic [47:0] s_tdata,   // [47:0] mac
	input  wire logic        s_tuser,   // [0] cmd
	output      logic        m_tvalid,
	input  wire logic        m_tready,
	output      logic [31:0] m_tdata,   // [31:0] mac_hash
	output      logic        m_tuser    // [0] seen
);
	import rmdc_pkg::*;

	localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [IW-1:0] LAST_STEP = IW'(DEPTH - 1);
	localparam logic [CW-1:0] FULL      = CW'(DEPTH);

	ctrl_state_t       state_q, state_d;
	chain_ctl_t        ctl;
	logic [IW-1:0]     step_q;
	logic [CW-1:0]     count_q;
	logic              hit_q;
	logic              clear_q;
	logic              accept;
	logic              hash_start;
	logic              hash_done;
	logic              out_load;
	logic              tap_valid;
	logic              tap_hit;
	logic [IW-1:0]     tap_idx;
	logic [HASH_W-1:0] hash;
	logic [HASH_W-1:0] tail;
	logic              m_tvalid_q;
	logic [HASH_W-1:0] m_tdata_q;
	logic              m_tuser_q;

	assign accept = s_tvalid && s_tready;

	rmdc_hash u_hash (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (hash_start),
		.mac    (s_tdata),
		.hash   (hash),
		.done   (hash_done)
	);

	rmdc_chain #(
		.DEPTH (DEPTH)
	) u_chain (
		.clk     (clk),
		.ctl     (ctl),
		.hash_in (hash),
		.tail    (tail)
	);

	// tail cell holds the entry that sat LAST_STEP - step cells from the head
	assign tap_idx   = LAST_STEP - step_q;
	assign tap_valid = CW'(tap_idx) < count_q;
	assign tap_hit   = (state_q == ST_SEARCH) && tap_valid && (tail == hash);

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					state_d = (s_tuser == CMD_CLEAR) ? ST_DONE : ST_HASH;
				end
			end
			ST_HASH: begin
				if (hash_done) begin
					state_d = ST_SEARCH;
				end
			end
			ST_SEARCH: begin
				if (step_q == LAST_STEP) begin
					state_d = (hit_q || tap_hit) ? ST_DONE : ST_INSERT;
				end
			end
			ST_INSERT: begin
				state_d = ST_DONE;
			end
			ST_DONE: begin
				if (!m_tvalid_q || m_tready) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_comb begin
		s_tready     = 1'b0;
		hash_start   = 1'b0;
		ctl.advance  = 1'b0;
		ctl.load_new = 1'b0;
		out_load     = 1'b0;
		case (state_q)
			ST_IDLE: begin
				s_tready   = 1'b1;
				hash_start = s_tvalid && (s_tuser == CMD_CHECK);
			end
			ST_SEARCH: begin
				ctl.advance = 1'b1;
			end
			ST_INSERT: begin
				ctl.advance  = 1'b1;
				ctl.load_new = 1'b1;
			end
			ST_DONE: begin
				out_load = !m_tvalid_q || m_tready;
			end
			default: begin
				s_tready = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			step_q     <= '0;
			count_q    <= '0;
			hit_q      <= 1'b0;
			clear_q    <= 1'b0;
			m_tvalid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (accept) begin
				step_q  <= '0;
				hit_q   <= 1'b0;
				clear_q <= (s_tuser == CMD_CLEAR);
				if (s_tuser == CMD_CLEAR) begin
					count_q <= '0;
				end
			end
			if (state_q == ST_SEARCH) begin
				hit_q  <= hit_q || tap_hit;
				step_q <= (step_q == LAST_STEP) ? '0 : step_q + 1'b1;
			end
			// the oldest entry drops off the end once the chain is full
			if (state_q == ST_INSERT && count_q != FULL) begin
				count_q <= count_q + 1'b1;
			end
			if (out_load) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			m_tdata_q <= clear_q ? '0 : hash;
			m_tuser_q <= clear_q ? 1'b0 : hit_q;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;

`ifndef SYNTH
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= FULL)
		else $error("entry count beyond depth");
	a_clear_empties: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && s_tuser == CMD_CLEAR) |=> count_q == '0)
		else $error("clear did not empty the cache");
	a_result_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(state_q) == ST_DONE)
		else $error("result raised outside the done state");
	a_insert_only_on_miss: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.load_new |-> !hit_q)
		else $error("chain loaded on a hit");
`endif

endmodule
`default_nettype wire

@@ hdl/rmdc_cell.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Dedup cache cell
// Holds one stored hash and hands it to the next cell when the chain advances.
// ----------------------------------------------------------------------------
module rmdc_cell (
	input  wire logic                       clk,
	input  wire logic                       advance,
	input  wire logic [rmdc_pkg::HASH_W-1:0] din,
	output      logic [rmdc_pkg::HASH_W-1:0] dout
);
	import rmdc_pkg::*;

	logic [HASH_W-1:0] word_q;

	always_ff @(posedge clk) begin
		if (advance) begin
			word_q <= din;
		end
	end

	assign dout = word_q;

endmodule
`default_nettype wire

@@ hdl/rmdc_chain.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Dedup cache cell chain
// A row of DEPTH cells. Cell 0 holds the newest hash; the tail wraps back to
// cell 0 during a search so that a full pass restores the original order.
// ----------------------------------------------------------------------------
module rmdc_chain #(
	parameter int DEPTH = rmdc_pkg::DEPTH_DEF
) (
	input  wire logic                        clk,
	input  wire rmdc_pkg::chain_ctl_t        ctl,
	input  wire logic [rmdc_pkg::HASH_W-1:0] hash_in,
	output      logic [rmdc_pkg::HASH_W-1:0] tail
);
	import rmdc_pkg::*;

	logic [HASH_W-1:0] link [DEPTH];
	logic [HASH_W-1:0] head_in;

	// take the new hash on insert, otherwise recirculate the tail
	assign head_in = ctl.load_new ? hash_in : link[DEPTH-1];

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		if (i == 0) begin : g_head
			rmdc_cell u_cell (
				.clk     (clk),
				.advance (ctl.advance),
				.din     (head_in),
				.dout    (link[i])
			);
		end else begin : g_body
			rmdc_cell u_cell (
				.clk     (clk),
				.advance (ctl.advance),
				.din     (link[i-1]),
				.dout    (link[i])
			);
		end
	end

	assign tail = link[DEPTH-1];

endmodule
`default_nettype wire

@@ hdl/rmdc_hash.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// MAC hash unit
// Folds the six MAC bytes, first byte first, one byte per cycle:
// hash = hash * 33 ^ byte, starting from the seed.
// ----------------------------------------------------------------------------
module rmdc_hash (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        start,
	input  wire logic [rmdc_pkg::MAC_W-1:0]  mac,
	output      logic [rmdc_pkg::HASH_W-1:0] hash,
	output      logic                        done
);
	import rmdc_pkg::*;

	logic [MAC_W-1:0]      mac_q;
	logic [HASH_W-1:0]     hash_q;
	logic [BYTE_CNT_W-1:0] cnt_q;
	logic                  busy_q;
	logic                  done_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= BYTE_CNT_W'(MAC_BYTES);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == BYTE_CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			mac_q  <= mac;
			hash_q <= HASH_SEED;
		end else if (busy_q) begin
			mac_q  <= {mac_q[MAC_W-9:0], 8'h00};
			hash_q <= ((hash_q << 5) + hash_q) ^ {24'h000000, mac_q[MAC_W-1 -: 8]};
		end
	end

	assign hash = hash_q;
	assign done = done_q;

`ifndef SYNTH
	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> $past(busy_q))
		else $error("hash done without a running fold");
	a_no_start_while_busy: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> !start)
		else $error("hash restarted mid fold");
	a_done_single: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |=> !done_q)
		else $error("hash done held for more than one cycle");
`endif

endmodule
`default_nettype wire
